// ===== hdl/pcx_rle_scanline_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// PCX scanline decoder assertion macros
// Concurrent property shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_SCANLINE_DECODER_TOP_MACROS_SVH
`define PCX_RLE_SCANLINE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCX_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pcx_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX scanline decoder package
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package pcx_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int POS_BITS      = 18;

    localparam logic [15:0] COORD_MASK = 16'((32'd1 << COORD_BITS) - 32'd1);

    localparam logic [7:0] COUNT_MARK = 8'hC0;
    localparam logic [7:0] COUNT_BITS = 8'h3F;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_BYTES  = 8'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THREE_PLANES = 8'd3;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [15:0] plane_line_bytes;
        logic        three_planes;
    } cfg_t;

    typedef struct packed {
        logic cap_count;   // store run length from a count byte
        logic load;        // start a run with the current byte as value
        logic use_run;     // run length comes from the stored count
        logic step;        // emit one copy into the output register
    } cmd_t;

    typedef struct packed {
        logic is_count;    // input byte has both top bits set
        logic run_zero;    // stored run length is zero
        logic out_free;    // output register can take a copy this cycle
        logic last;        // the copy now being formed ends the run
    } stat_t;

endpackage

// ===== hdl/pcx_rle_scanline_decoder_top.sv =====
// ----------------------------------------------------------------------------
// PCX run-length scanline decoder, top level
// Turns a PCX run-length byte stream into addressed pixel-byte writes.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one encoded byte per transaction. A byte with both top bits
//   set is a count byte (low six bits are the run); it yields no write and
//   the next byte is the value. Any other byte is a single literal.
//   m_ channel: one transaction per pixel-byte write, carrying row, column,
//   component and value, plus the in-width, line-end and image-end flags.
//   tlast marks the final write caused by one value byte.
//   cfg channel: index/data writes to image_width, image_height, plane_line_bytes
//   and three_planes; always ready; write only while idle, not enforced by the block.
// Flow:
//   A literal byte is issued as a run of one copy. Count bytes and
//   zero-length runs leave the controller idle. s_tready is low while a
//   run is issued at one copy per cycle while m_tready allows; the first
//   write is registered after the value byte moves the controller to run.
// Reset (aresetn low, synchronous): position returns to row 0, column 0,
//   no count is pending, the output register empties and the registers
//   return to 640 x 480, 640 bytes per plane, one plane.
// Stall: while m_tready is low the held write stays put; the run pauses
//   and s_tready stays low until the run has been fully issued.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // encoded stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] data_byte
    // pixel writes
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // [15:0] row, [31:16] column,
                                                         // [39:32] pixel_value
    output logic                              m_tlast,   // last_copy
    output logic [7:0]                        m_tuser,   // [1:0] component, [2] in_width,
                                                         // [3] line_end, [4] image_end
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcx_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);
    import pcx_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    // register file
    pcx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // byte classification and run sequencing
    pcx_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // position counters and output register
    pcx_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_byte  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/pcx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PCX configuration registers
// Register file behind the configuration write channel.
// ----------------------------------------------------------------------------
module pcx_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcx_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data,
    output pcx_pkg::cfg_t                     cfg
);
    import pcx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width      = cfg_data;
                REG_IMAGE_HEIGHT: cfg_next.image_height     = cfg_data;
                REG_PLANE_BYTES:  cfg_next.plane_line_bytes = cfg_data;
                REG_THREE_PLANES: cfg_next.three_planes     = cfg_data[0];
                default:          cfg_next = cfg_reg;   // unknown index ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width      <= 16'd640;
            cfg_reg.image_height     <= 16'd480;
            cfg_reg.plane_line_bytes <= 16'd640;
            cfg_reg.three_planes     <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/pcx_ctrl.sv =====
// ----------------------------------------------------------------------------
// PCX decoder controller
// Sorts count, value and literal bytes and sequences the copies of a run.
// ----------------------------------------------------------------------------
module pcx_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  pcx_pkg::stat_t  stat,
    output pcx_pkg::cmd_t   cmd
);
    import pcx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic pending_reg, pending_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next   = state_reg;
        pending_next = pending_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (pending_reg) begin
                        pending_next = 1'b0;
                        cmd.use_run  = 1'b1;
                        if (!stat.run_zero) begin
                            cmd.load   = 1'b1;
                            state_next = ST_RUN;
                        end
                    end else if (stat.is_count) begin
                        cmd.cap_count = 1'b1;
                        pending_next  = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (stat.out_free) begin
                    cmd.step = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== hdl/pcx_dp.sv =====
// ----------------------------------------------------------------------------
// PCX decoder datapath
// Scanline position counters, run counter and the output register.
// ----------------------------------------------------------------------------
module pcx_dp (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pcx_pkg::cfg_t         cfg,
    input  logic [7:0]            in_byte,
    input  pcx_pkg::cmd_t         cmd,
    output pcx_pkg::stat_t        stat,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,
    output logic                  m_tlast,
    output logic [7:0]            m_tuser
);
    import pcx_pkg::*;

    // run and position state
    logic [5:0]          run_reg;
    logic [5:0]          remain_reg;
    logic [7:0]          value_reg;
    logic [POS_BITS-1:0] len_reg;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [15:0]         pcol_reg, pcol_next;
    logic [1:0]          pidx_reg, pidx_next;
    logic [15:0]         row_reg, row_next;

    // output register
    logic                out_valid_reg;
    logic [15:0]         o_row_reg, o_col_reg;
    logic [1:0]          o_comp_reg;
    logic [7:0]          o_val_reg;
    logic                o_inw_reg, o_last_reg, o_lend_reg, o_iend_reg;

    logic [POS_BITS-1:0] col;
    logic [POS_BITS-1:0] pos_inc;
    logic [POS_BITS-1:0] plb_1x, plb_2x, len_calc;
    logic [1:0]          comp;
    logic                in_w, lend, row_last, last;

    assign plb_1x   = {2'b00, cfg.plane_line_bytes};
    assign plb_2x   = {1'b0, cfg.plane_line_bytes, 1'b0};
    assign len_calc = cfg.three_planes ? (plb_2x + plb_1x) : plb_1x;

    assign col      = cfg.three_planes ? {2'b00, pcol_reg} : pos_reg;
    assign comp     = cfg.three_planes ? pidx_reg : 2'd0;
    assign in_w     = (col < {2'b00, cfg.image_width});
    assign pos_inc  = pos_reg + 1'b1;
    assign lend     = (pos_inc >= len_reg);
    assign row_last = ({1'b0, row_reg} + 17'd1) >= {1'b0, cfg.image_height};
    assign last     = lend || (remain_reg == 6'd1);

    assign stat.is_count = ((in_byte & COUNT_MARK) == COUNT_MARK);
    assign stat.run_zero = (run_reg == 6'd0);
    assign stat.out_free = !out_valid_reg || m_tready;
    assign stat.last     = last;

    always_comb begin
        pos_next  = pos_inc;
        pcol_next = pcol_reg;
        pidx_next = pidx_reg;
        row_next  = row_reg;
        if (lend) begin
            pos_next  = '0;
            pcol_next = '0;
            pidx_next = 2'd0;
            row_next  = row_last ? 16'd0 : row_reg + 16'd1;
        end else if (cfg.three_planes) begin
            if (pos_inc == plb_1x) begin
                pcol_next = '0;
                pidx_next = 2'd1;
            end else if (pos_inc == plb_2x) begin
                pcol_next = '0;
                pidx_next = 2'd2;
            end else begin
                pcol_next = pcol_reg + 16'd1;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg       <= '0;
            pos_reg       <= '0;
            pcol_reg      <= '0;
            pidx_reg      <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.cap_count) begin
                run_reg <= 6'(in_byte & COUNT_BITS);
            end
            if (cmd.step) begin
                pos_reg  <= pos_next;
                pcol_reg <= pcol_next;
                pidx_reg <= pidx_next;
                row_reg  <= row_next;
            end
            if (cmd.step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            remain_reg <= cmd.use_run ? run_reg : 6'd1;
            value_reg  <= in_byte;
            len_reg    <= len_calc;
        end else if (cmd.step) begin
            remain_reg <= remain_reg - 6'd1;
        end
        if (cmd.step) begin
            o_row_reg  <= row_reg & COORD_MASK;
            o_col_reg  <= col[15:0] & COORD_MASK;
            o_comp_reg <= comp;
            o_val_reg  <= value_reg;
            o_inw_reg  <= in_w;
            o_last_reg <= last;
            o_lend_reg <= lend;
            o_iend_reg <= lend && row_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {o_val_reg, o_col_reg, o_row_reg};
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {3'b000, o_iend_reg, o_lend_reg, o_inw_reg, o_comp_reg};

endmodule

// ===== hdl/pcx_chk.sv =====
// ----------------------------------------------------------------------------
// PCX decoder port checker
// Watches the top-level ports and flags protocol and flag-coding slips.
// ----------------------------------------------------------------------------
`include "pcx_rle_scanline_decoder_top_macros.svh"

module pcx_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast,
    input logic [7:0]  m_tuser
);

    `PCX_ASSERT_NEXT(a_valid_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
    `PCX_ASSERT_NEXT(a_data_holds, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "m_ payload changed while stalled")
    `PCX_ASSERT_NOW(a_comp_range, aclk, aresetn, m_tvalid, m_tuser[1:0] != 2'b11, "component code out of range")
    `PCX_ASSERT_NOW(a_end_flags, aclk, aresetn, m_tvalid && (m_tuser[3] || m_tuser[4]), m_tlast && m_tuser[3], "line or image end without run end")

endmodule

bind pcx_rle_scanline_decoder_top pcx_chk u_pcx_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/tb_pcx_rle_scanline_decoder_top.sv =====
// ----------------------------------------------------------------------------
// PCX run-length scanline decoder testbench
// Feeds encoded byte streams under several register settings and flow
// patterns. A local decoder model predicts every pixel-byte write, and each
// write leaving the block is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_pcx_rle_scanline_decoder_top;
    import pcx_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;    // count bytes leave no write behind
    localparam int LONG_STALL   = 400;

    typedef enum {FLOW_FREE, FLOW_SEND_IDLE, FLOW_RECV_STALL, FLOW_BOTH} flow_mode_t;

    typedef struct {
        logic [15:0] row;
        logic [15:0] column;
        logic [1:0]  component;
        logic [7:0]  value;
        logic        in_width;
        logic        last_copy;
        logic        line_end;
        logic        image_end;
    } pixel_write_t;

    // ------------------------------------------------------------------------
    // DUT signals, all known from time zero
    // ------------------------------------------------------------------------
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic [7:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [15:0] cfg_data  = 16'h0000;

    pcx_rle_scanline_decoder_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    logic [7:0]   byte_q [$];           // encoded bytes not yet accepted
    pixel_write_t expected_writes [$];  // predicted writes, oldest first
    pixel_write_t want_w;
    logic [7:0]   taken_byte;
    logic         byte_taken = 1'b0;    // s_ transaction at the last rising edge
    int           cycle_cnt = 0;
    int           err_cnt = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           long_stall_req = 1'b0;
    bit           long_stall_done = 1'b0;
    int           long_stall_cnt = 0;

    // decoder model: registers at their reset values
    logic [15:0]  mdl_width  = 16'd640;
    logic [15:0]  mdl_height = 16'd480;
    logic [15:0]  mdl_plb    = 16'd640;
    logic         mdl_three  = 1'b0;
    // decoder model: position and pending-count state
    logic         pend_count = 1'b0;
    logic [5:0]   run_len    = '0;
    int unsigned  line_pos   = 0;
    logic [15:0]  plane_col  = '0;
    logic [1:0]   plane_idx  = '0;
    logic [15:0]  cur_row    = '0;

    task automatic report_mismatch(input string msg);
        $display("mismatch @%0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    // Expands one accepted byte into the pixel writes it causes.
    task automatic decode_byte(input logic [7:0] b);
        int unsigned  count;
        int unsigned  line_len;
        int unsigned  col;
        int unsigned  k;
        bit           lend;
        bit           iend;
        pixel_write_t w;
        if (!pend_count && ((b & COUNT_MARK) == COUNT_MARK)) begin
            // count byte: remember the run, the value byte comes next
            pend_count = 1'b1;
            run_len = 6'(b & COUNT_BITS);
        end else begin
            count = pend_count ? int'(run_len) : 1;
            pend_count = 1'b0;
            line_len = mdl_three ? int'(mdl_plb) * 3 : int'(mdl_plb);
            lend = 1'b0;
            for (k = 0; k < count && !lend; k++) begin
                iend = 1'b0;
                col = mdl_three ? int'(plane_col) : line_pos;
                w.row       = cur_row;
                w.column    = 16'(col);
                w.component = mdl_three ? plane_idx : 2'd0;
                w.value     = b;
                w.in_width  = (col < int'(mdl_width));
                line_pos = (line_pos + 1) & 32'h3FFFF;
                if (line_pos >= line_len) begin
                    lend = 1'b1;
                    // last row also catches a height at zero or below the row
                    if (int'(cur_row) + 1 >= int'(mdl_height)) begin
                        iend = 1'b1;
                        cur_row = '0;
                    end else begin
                        cur_row = cur_row + 16'd1;
                    end
                    line_pos  = 0;
                    plane_col = '0;
                    plane_idx = '0;
                end else if (mdl_three) begin
                    if (line_pos == int'(mdl_plb)) begin
                        plane_col = '0;
                        plane_idx = 2'd1;
                    end else if (line_pos == int'(mdl_plb) * 2) begin
                        plane_col = '0;
                        plane_idx = 2'd2;
                    end else begin
                        plane_col = plane_col + 16'd1;
                    end
                end
                w.last_copy = lend || (k + 1 == count);
                w.line_end  = lend;
                w.image_end = iend;
                expected_writes.push_back(w);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued bytes at the falling edge, random idle gaps
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!s_tvalid || byte_taken) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_q[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off counted here
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (long_stall_req && !long_stall_done) begin
            m_tready <= 1'b0;
            if (long_stall_cnt == LONG_STALL) begin
                long_stall_done <= 1'b1;
            end else begin
                long_stall_cnt <= long_stall_cnt + 1;
            end
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples every transaction at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("TB_ERROR");
            $finish;
        end else begin
            byte_taken <= s_tvalid && s_tready;
            if (aresetn) begin
                // the block must be written only while idle; it does not enforce this itself
                if (cfg_valid && cfg_ready) begin
                    case (cfg_index)
                        REG_IMAGE_WIDTH:  mdl_width  = cfg_data;
                        REG_IMAGE_HEIGHT: mdl_height = cfg_data;
                        REG_PLANE_BYTES:  mdl_plb    = cfg_data;
                        REG_THREE_PLANES: mdl_three  = cfg_data[0];
                        default: ;  // unknown index is dropped
                    endcase
                end
                if (s_tvalid && s_tready) begin
                    decode_byte(s_tdata);
                    taken_byte = byte_q.pop_front();
                end
                if (m_tvalid && m_tready) begin
                    if (expected_writes.size() == 0) begin
                        report_mismatch($sformatf("unexpected write row %0d col %0d val %02h",
                            m_tdata[15:0], m_tdata[31:16], m_tdata[39:32]));
                    end else begin
                        want_w = expected_writes.pop_front();
                        if (m_tdata[15:0] !== want_w.row)
                            report_mismatch($sformatf("row %0d, want %0d",
                                m_tdata[15:0], want_w.row));
                        if (m_tdata[31:16] !== want_w.column)
                            report_mismatch($sformatf("column %0d, want %0d",
                                m_tdata[31:16], want_w.column));
                        if (m_tdata[39:32] !== want_w.value)
                            report_mismatch($sformatf("pixel_value %02h, want %02h",
                                m_tdata[39:32], want_w.value));
                        if (m_tuser[1:0] !== want_w.component)
                            report_mismatch($sformatf("component %0d, want %0d",
                                m_tuser[1:0], want_w.component));
                        if (m_tuser[2] !== want_w.in_width)
                            report_mismatch($sformatf("in_width %b, want %b",
                                m_tuser[2], want_w.in_width));
                        if (m_tlast !== want_w.last_copy)
                            report_mismatch($sformatf("last_copy %b, want %b",
                                m_tlast, want_w.last_copy));
                        if (m_tuser[3] !== want_w.line_end)
                            report_mismatch($sformatf("line_end %b, want %b",
                                m_tuser[3], want_w.line_end));
                        if (m_tuser[4] !== want_w.image_end)
                            report_mismatch($sformatf("image_end %b, want %b",
                                m_tuser[4], want_w.image_end));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Full register set, plus one write to an index the block must ignore.
    task automatic apply_setting(input logic [15:0] w, input logic [15:0] h,
                                 input logic [15:0] plb, input logic tp);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(CFG_IDX_BITS'($urandom_range(4, 255)), 16'($urandom));
        write_reg(REG_PLANE_BYTES, plb);
        // upper data bits are don't-care for the mode flag
        write_reg(REG_THREE_PLANES, {15'($urandom), tp});
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_flow(input flow_mode_t mode);
        case (mode)
            FLOW_FREE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            FLOW_SEND_IDLE:  begin send_idle_pct = 75; recv_stall_pct = 0;  end
            FLOW_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            default:         begin send_idle_pct = 33; recv_stall_pct = 33; end
        endcase
    endtask

    // Mostly literals and count/value pairs, some stray bytes as noise.
    task automatic gen_stream(input int n);
        int   cnt;
        int   r;
        int   run;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 45) begin
                byte_q.push_back(8'($urandom_range(0, 8'hBF)));
                cnt++;
            end else if (r < 85) begin
                r = $urandom_range(99);
                if (r < 8)       run = 0;
                else if (r < 70) run = $urandom_range(1, 6);
                else if (r < 90) run = $urandom_range(7, 20);
                else             run = $urandom_range(21, 63);
                byte_q.push_back(COUNT_MARK | 8'(run));
                byte_q.push_back(8'($urandom_range(255)));
                cnt += 2;
            end else begin
                byte_q.push_back(8'($urandom_range(255)));
                cnt++;
            end
        end
    endtask

    // Sender holds off until every predicted write has come out.
    task automatic wait_drained();
        while (byte_q.size() != 0 || expected_writes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0] seq_reset_cfg [11];
        logic [7:0] seq_planes [10];
        int         p;
        // literals at both ends, short run, full run, zero run,
        // and a value byte that looks like a count byte
        seq_reset_cfg = '{8'h00, 8'hBF, 8'h7E, 8'hC1, 8'hFF, 8'hFF, 8'hC0,
                          8'hC0, 8'h55, 8'hC5, 8'hC3};
        // plane changes, clipping, run past line end, image end and wrap
        seq_planes = '{8'hC9, 8'h11, 8'hC5, 8'h22, 8'h01, 8'h80, 8'hCF,
                       8'h33, 8'hC3, 8'h44};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: registers left at their reset values
        set_flow(FLOW_FREE);
        foreach (seq_reset_cfg[i]) byte_q.push_back(seq_reset_cfg[i]);
        wait_drained();

        // directed: tiny three-plane image
        apply_setting(16'd3, 16'd2, 16'd4, 1'b1);
        foreach (seq_planes[i]) byte_q.push_back(seq_planes[i]);
        wait_drained();

        // random phases; settings carry over position state between them
        for (p = 0; p < 10; p++) begin
            case (p)
                0: begin
                    apply_setting(16'($urandom_range(1, 24)), 16'($urandom_range(1, 5)),
                                  16'($urandom_range(1, 16)), 1'b0);
                    set_flow(FLOW_FREE);
                    gen_stream(45);
                end
                1: begin
                    apply_setting(16'($urandom_range(1, 24)), 16'($urandom_range(1, 5)),
                                  16'($urandom_range(1, 8)), 1'b1);
                    set_flow(FLOW_SEND_IDLE);
                    gen_stream(45);
                end
                2: begin
                    apply_setting(16'($urandom_range(1, 24)), 16'($urandom_range(1, 5)),
                                  16'($urandom_range(1, 16)), 1'($urandom));
                    set_flow(FLOW_RECV_STALL);
                    gen_stream(45);
                end
                3: begin
                    apply_setting(16'($urandom_range(1, 24)), 16'($urandom_range(1, 5)),
                                  16'($urandom_range(1, 16)), 1'($urandom));
                    set_flow(FLOW_BOTH);
                    gen_stream(45);
                end
                4: begin
                    // receiver holds off long while the sender keeps offering
                    apply_setting(16'd8, 16'd3, 16'd6, 1'b1);
                    set_flow(FLOW_FREE);
                    long_stall_req = 1'b1;
                    gen_stream(40);
                end
                5: begin
                    // largest values everywhere: line never ends here
                    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
                    set_flow(FLOW_BOTH);
                    gen_stream(35);
                end
                6: begin
                    // short lines in a tall image push the row up
                    apply_setting(16'd1, 16'hFFFF, 16'd2, 1'b0);
                    set_flow(FLOW_RECV_STALL);
                    gen_stream(35);
                end
                7: begin
                    // height dropped below the current row
                    apply_setting(16'd0, 16'd1, 16'd3, 1'b1);
                    set_flow(FLOW_SEND_IDLE);
                    gen_stream(30);
                end
                8: begin
                    // zero line length and zero height: every copy ends the image
                    apply_setting(16'd0, 16'd0, 16'd0, 1'b0);
                    set_flow(FLOW_FREE);
                    gen_stream(30);
                end
                default: begin
                    apply_setting(16'($urandom), 16'($urandom_range(1, 6)),
                                  16'($urandom_range(1, 12)), 1'($urandom));
                    set_flow(FLOW_BOTH);
                    gen_stream(40);
                end
            endcase
            wait_drained();
        end

        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/pcx_pkg.sv
hdl/pcx_cfg_regs.sv
hdl/pcx_ctrl.sv
hdl/pcx_dp.sv
hdl/pcx_rle_scanline_decoder_top.sv
hdl/pcx_chk.sv
test/tb_pcx_rle_scanline_decoder_top.sv
